/* rtl/core/c_like_token_scanner_core_defines.svh */
// Assertion helpers for the token scanner core
`ifndef C_LIKE_TOKEN_SCANNER_CORE_DEFINES_SVH
`define C_LIKE_TOKEN_SCANNER_CORE_DEFINES_SVH

// check cons in the same cycle as ante
`define CTLS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// check cons in the cycle after ante
`define CTLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/ctls_pkg.sv */
package ctls_pkg;

	localparam int QDEPTH = 8;
	localparam int QAW = $clog2(QDEPTH);
	localparam int CNT_W = QAW + 1;

	localparam logic [3:0] K_OPER   = 4'd0;
	localparam logic [3:0] K_COMMA  = 4'd1;
	localparam logic [3:0] K_LPAREN = 4'd2;
	localparam logic [3:0] K_RPAREN = 4'd3;
	localparam logic [3:0] K_LBRACE = 4'd4;
	localparam logic [3:0] K_RBRACE = 4'd5;
	localparam logic [3:0] K_SEMI   = 4'd6;
	localparam logic [3:0] K_NUM    = 4'd7;
	localparam logic [3:0] K_IDENT  = 4'd8;
	localparam logic [3:0] K_END    = 4'd9;
	localparam logic [3:0] K_ERR    = 4'd10;

	localparam logic [7:0] CH_TAB        = 8'h09;
	localparam logic [7:0] CH_LF         = 8'h0A;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_BANG       = 8'h21;
	localparam logic [7:0] CH_PERCENT    = 8'h25;
	localparam logic [7:0] CH_LPAREN     = 8'h28;
	localparam logic [7:0] CH_RPAREN     = 8'h29;
	localparam logic [7:0] CH_STAR       = 8'h2A;
	localparam logic [7:0] CH_PLUS       = 8'h2B;
	localparam logic [7:0] CH_COMMA      = 8'h2C;
	localparam logic [7:0] CH_MINUS      = 8'h2D;
	localparam logic [7:0] CH_SLASH      = 8'h2F;
	localparam logic [7:0] CH_DIGIT_LO   = 8'h30;
	localparam logic [7:0] CH_DIGIT_HI   = 8'h39;
	localparam logic [7:0] CH_SEMI       = 8'h3B;
	localparam logic [7:0] CH_LT         = 8'h3C;
	localparam logic [7:0] CH_EQ         = 8'h3D;
	localparam logic [7:0] CH_GT         = 8'h3E;
	localparam logic [7:0] CH_UPPER_LO   = 8'h41;
	localparam logic [7:0] CH_UPPER_HI   = 8'h5A;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_LOWER_LO   = 8'h61;
	localparam logic [7:0] CH_LOWER_HI   = 8'h7A;
	localparam logic [7:0] CH_LBRACE     = 8'h7B;
	localparam logic [7:0] CH_RBRACE     = 8'h7D;
	localparam logic [7:0] CH_HIGH       = 8'h80;

	typedef struct packed {
		logic [3:0] kind;
		logic [7:0] chr;
		logic       char_valid;
		logic       last;
	} tok_t;

	typedef struct packed {
		logic [1:0] cnt;
		tok_t       e0;
		tok_t       e1;
	} push_t;

endpackage

/* rtl/core/ctls_if.sv */
interface ctls_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] source_byte;
	logic       end_of_input;

	modport source (output valid, output source_byte, output end_of_input, input ready);
	modport sink (input valid, input source_byte, input end_of_input, output ready);
endinterface

interface ctls_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] token_kind;
	logic [7:0] token_char;
	logic       char_valid;
	logic       token_last;

	modport source (output valid, output token_kind, output token_char, output char_valid,
		output token_last, input ready);
	modport sink (input valid, input token_kind, input token_char, input char_valid,
		input token_last, output ready);
endinterface

/* rtl/core/ctls_front.sv */
module ctls_front (
	input  logic            clk,
	input  logic            arst_n,
	ctls_in_if.sink         byte_stream,
	input  logic            space_ok,
	output ctls_pkg::push_t push
);

	typedef enum logic [10:0] {
		M_IDLE  = 11'b000_0000_0001,
		M_NUM   = 11'b000_0000_0010,
		M_IDENT = 11'b000_0000_0100,
		M_SLASH = 11'b000_0000_1000,
		M_GT    = 11'b000_0001_0000,
		M_LT    = 11'b000_0010_0000,
		M_EQ    = 11'b000_0100_0000,
		M_BANG  = 11'b000_1000_0000,
		M_LINE  = 11'b001_0000_0000,
		M_BLOCK = 11'b010_0000_0000,
		M_STAR  = 11'b100_0000_0000
	} mode_t;

	typedef struct packed {
		logic             emit;
		ctls_pkg::tok_t   tok;
		mode_t            mode;
		logic [3:0]       kind;
	} start_t;

	mode_t      mode_q;
	logic [7:0] held_char_q;
	logic [3:0] held_kind_q;

	mode_t      nxt_mode;
	logic [7:0] nxt_char;
	logic [3:0] nxt_kind;
	logic [1:0] n;
	ctls_pkg::tok_t e0;
	ctls_pkg::tok_t e1;
	ctls_pkg::tok_t held_last;
	ctls_pkg::tok_t held_more;
	start_t     st;
	logic [7:0] b;
	logic       holding;
	logic       accept;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= ctls_pkg::CH_DIGIT_LO) && (c <= ctls_pkg::CH_DIGIT_HI);
	endfunction

	function automatic logic is_ident(input logic [7:0] c);
		return is_digit(c)
			|| ((c >= ctls_pkg::CH_UPPER_LO) && (c <= ctls_pkg::CH_UPPER_HI))
			|| ((c >= ctls_pkg::CH_LOWER_LO) && (c <= ctls_pkg::CH_LOWER_HI))
			|| (c == ctls_pkg::CH_UNDERSCORE) || (c >= ctls_pkg::CH_HIGH);
	endfunction

	function automatic start_t start_fn(input logic [7:0] c);
		start_t r;
		r.emit = 1'b0;
		r.tok  = '{kind: ctls_pkg::K_OPER, chr: c, char_valid: 1'b1, last: 1'b1};
		r.mode = M_IDLE;
		r.kind = ctls_pkg::K_OPER;
		unique case (c)
			ctls_pkg::CH_SPACE, ctls_pkg::CH_TAB, ctls_pkg::CH_LF: begin
			end
			ctls_pkg::CH_SLASH: r.mode = M_SLASH;
			ctls_pkg::CH_GT:    r.mode = M_GT;
			ctls_pkg::CH_LT:    r.mode = M_LT;
			ctls_pkg::CH_EQ:    r.mode = M_EQ;
			ctls_pkg::CH_BANG:  r.mode = M_BANG;
			ctls_pkg::CH_PLUS, ctls_pkg::CH_MINUS, ctls_pkg::CH_STAR,
			ctls_pkg::CH_PERCENT: r.emit = 1'b1;
			ctls_pkg::CH_COMMA: begin
				r.emit = 1'b1;
				r.tok.kind = ctls_pkg::K_COMMA;
			end
			ctls_pkg::CH_LPAREN: begin
				r.emit = 1'b1;
				r.tok.kind = ctls_pkg::K_LPAREN;
			end
			ctls_pkg::CH_RPAREN: begin
				r.emit = 1'b1;
				r.tok.kind = ctls_pkg::K_RPAREN;
			end
			ctls_pkg::CH_LBRACE: begin
				r.emit = 1'b1;
				r.tok.kind = ctls_pkg::K_LBRACE;
			end
			ctls_pkg::CH_RBRACE: begin
				r.emit = 1'b1;
				r.tok.kind = ctls_pkg::K_RBRACE;
			end
			ctls_pkg::CH_SEMI: begin
				r.emit = 1'b1;
				r.tok.kind = ctls_pkg::K_SEMI;
			end
			default: begin
				priority if (is_digit(c)) begin
					r.mode = M_NUM;
					r.kind = ctls_pkg::K_NUM;
				end else if (is_ident(c)) begin
					r.mode = M_IDENT;
					r.kind = ctls_pkg::K_IDENT;
				end else begin
					r.emit = 1'b1;
					r.tok.kind = ctls_pkg::K_ERR;
				end
			end
		endcase
		return r;
	endfunction

	assign b       = byte_stream.source_byte;
	assign accept  = byte_stream.valid && space_ok;
	assign holding = (mode_q == M_NUM) || (mode_q == M_IDENT) || (mode_q == M_SLASH)
		|| (mode_q == M_GT) || (mode_q == M_LT) || (mode_q == M_EQ) || (mode_q == M_BANG);

	assign byte_stream.ready = space_ok;

	always_comb begin
		st        = start_fn(b);
		held_last = '{kind: held_kind_q, chr: held_char_q, char_valid: 1'b1, last: 1'b1};
		held_more = '{kind: held_kind_q, chr: held_char_q, char_valid: 1'b1, last: 1'b0};
		n         = 2'd0;
		e0        = st.tok;
		e1        = st.tok;
		nxt_mode  = mode_q;
		nxt_char  = held_char_q;
		nxt_kind  = held_kind_q;
		if (byte_stream.end_of_input) begin
			nxt_mode = M_IDLE;
			if (holding) begin
				e0 = held_last;
				e1 = '{kind: ctls_pkg::K_END, chr: 8'h00, char_valid: 1'b0, last: 1'b1};
				n  = 2'd2;
			end else begin
				e0 = '{kind: ctls_pkg::K_END, chr: 8'h00, char_valid: 1'b0, last: 1'b1};
				n  = 2'd1;
			end
		end else begin
			unique case (mode_q)
				M_IDLE: begin
					n        = {1'b0, st.emit};
					nxt_mode = st.mode;
					nxt_char = b;
					nxt_kind = st.kind;
				end
				M_NUM, M_IDENT: begin
					if ((mode_q == M_NUM) ? is_digit(b) : is_ident(b)) begin
						e0       = held_more;
						n        = 2'd1;
						nxt_char = b;
					end else begin
						e0       = held_last;
						n        = 2'd1 + {1'b0, st.emit};
						nxt_mode = st.mode;
						nxt_char = b;
						nxt_kind = st.kind;
					end
				end
				M_SLASH: begin
					priority if (b == ctls_pkg::CH_SLASH) begin
						nxt_mode = M_LINE;
					end else if (b == ctls_pkg::CH_STAR) begin
						nxt_mode = M_BLOCK;
					end else begin
						e0       = held_last;
						n        = 2'd1 + {1'b0, st.emit};
						nxt_mode = st.mode;
						nxt_char = b;
						nxt_kind = st.kind;
					end
				end
				M_GT, M_LT, M_EQ, M_BANG: begin
					if ((b == ctls_pkg::CH_EQ)
						|| ((mode_q == M_GT) && (b == ctls_pkg::CH_GT))
						|| ((mode_q == M_LT) && (b == ctls_pkg::CH_LT))) begin
						e0       = held_more;
						e1       = '{kind: ctls_pkg::K_OPER, chr: b, char_valid: 1'b1,
							last: 1'b1};
						n        = 2'd2;
						nxt_mode = M_IDLE;
					end else begin
						e0       = held_last;
						n        = 2'd1 + {1'b0, st.emit};
						nxt_mode = st.mode;
						nxt_char = b;
						nxt_kind = st.kind;
					end
				end
				M_LINE: begin
					if (b == ctls_pkg::CH_LF) begin
						nxt_mode = M_IDLE;
					end
				end
				M_BLOCK: begin
					if (b == ctls_pkg::CH_STAR) begin
						nxt_mode = M_STAR;
					end
				end
				M_STAR: begin
					priority if (b == ctls_pkg::CH_SLASH) begin
						nxt_mode = M_IDLE;
					end else if (b != ctls_pkg::CH_STAR) begin
						nxt_mode = M_BLOCK;
					end
				end
				default: begin
					nxt_mode = M_IDLE;
				end
			endcase
		end
	end

	assign push.cnt = accept ? n : 2'd0;
	assign push.e0  = e0;
	assign push.e1  = e1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= M_IDLE;
			held_char_q <= 8'h00;
			held_kind_q <= 4'h0;
		end else if (accept) begin
			mode_q      <= nxt_mode;
			held_char_q <= nxt_char;
			held_kind_q <= nxt_kind;
		end
	end

endmodule

/* rtl/core/ctls_queue.sv */
`include "c_like_token_scanner_core_defines.svh"

module ctls_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  ctls_pkg::push_t push,
	output logic            space_ok,
	input  logic            pop,
	output logic            not_empty,
	output ctls_pkg::tok_t  head
);

	ctls_pkg::tok_t                 mem_q [ctls_pkg::QDEPTH];
	logic [ctls_pkg::QAW-1:0]       wr_ptr_q;
	logic [ctls_pkg::QAW-1:0]       rd_ptr_q;
	logic [ctls_pkg::CNT_W-1:0]     count_q;
	logic [ctls_pkg::QAW-1:0]       wr_ptr_p1;

	assign wr_ptr_p1 = wr_ptr_q + ctls_pkg::QAW'(1);
	assign space_ok  = count_q <= ctls_pkg::CNT_W'(ctls_pkg::QDEPTH - 2);
	assign not_empty = count_q != '0;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push.e0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_ptr_p1] <= push.e1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + ctls_pkg::QAW'(push.cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + ctls_pkg::QAW'(1);
			end
			count_q <= count_q + ctls_pkg::CNT_W'(push.cnt) - ctls_pkg::CNT_W'(pop);
		end
	end

	`CTLS_ASSERT_IMPL(a_no_overflow, clk, arst_n, push.cnt != 2'd0, (count_q + ctls_pkg::CNT_W'(push.cnt)) <= ctls_pkg::CNT_W'(ctls_pkg::QDEPTH), "queue overflow")
	`CTLS_ASSERT_IMPL(a_no_underflow, clk, arst_n, pop, count_q != '0, "pop from empty queue")
	`CTLS_ASSERT_IMPL(a_empty_ptrs, clk, arst_n, count_q == '0, rd_ptr_q == wr_ptr_q, "empty queue with pointers apart")
	`CTLS_ASSERT_NEXT(a_stay_empty, clk, arst_n, (count_q == '0) && (push.cnt == 2'd0), count_q == '0, "empty queue filled without a push")

endmodule

/* rtl/core/ctls_back.sv */
module ctls_back (
	input  logic           clk,
	input  logic           arst_n,
	input  ctls_pkg::tok_t head,
	input  logic           not_empty,
	output logic           pop,
	ctls_out_if.source     token_stream
);

	ctls_pkg::tok_t out_q;
	logic           out_valid_q;

	assign pop = not_empty && (!out_valid_q || token_stream.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || token_stream.ready) begin
			out_valid_q <= not_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= head;
		end
	end

	assign token_stream.valid      = out_valid_q;
	assign token_stream.token_kind = out_q.kind;
	assign token_stream.token_char = out_q.chr;
	assign token_stream.char_valid = out_q.char_valid;
	assign token_stream.token_last = out_q.last;

endmodule

/* rtl/core/c_like_token_scanner_core.sv */
// Token scanner for C-like source text. The byte_stream channel takes one source byte (or an
// end-of-input mark) per cycle while its ready is high, and the token_stream channel gives one
// token character per cycle while the sink is ready, tagged with its kind and a last flag; one
// character is held back until the next byte shows where the token ends. An item gives zero,
// one or two token characters: the front accepts an item every cycle while the 8-entry result
// queue has room for two more entries, and the output register drains one entry per cycle
// while token_stream is ready, so the sustained rate is one byte per cycle except where items
// that give two characters outrun the single output port. A character is written into the
// queue and then loaded into the output register, which presents it on token_stream.
module c_like_token_scanner_core (
	input  logic        clk,
	input  logic        arst_n,
	ctls_in_if.sink     byte_stream,
	ctls_out_if.source  token_stream
);

	ctls_pkg::push_t push;
	ctls_pkg::tok_t  head;
	logic            space_ok;
	logic            not_empty;
	logic            pop;

	ctls_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_stream (byte_stream),
		.space_ok    (space_ok),
		.push        (push)
	);

	ctls_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.space_ok  (space_ok),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	ctls_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.not_empty    (not_empty),
		.pop          (pop),
		.token_stream (token_stream)
	);

endmodule

/* tb/sv/c_like_token_scanner_core_tb.sv */
`timescale 1ns / 1ps

module c_like_token_scanner_core_tb;

	typedef enum logic [3:0] {
		SCAN_IDLE,
		SCAN_NUM,
		SCAN_IDENT,
		SCAN_SLASH,
		SCAN_GT,
		SCAN_LT,
		SCAN_EQ,
		SCAN_BANG,
		SCAN_LINE,
		SCAN_BLOCK,
		SCAN_STAR
	} scan_state_t;

	typedef struct packed {
		logic [7:0] data;
		logic       eoi;
	} src_item_t;

	logic clk = 1'b0;
	logic arst_n;

	ctls_in_if  byte_if();
	ctls_out_if token_if();

	c_like_token_scanner_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_stream  (byte_if),
		.token_stream (token_if)
	);

	always #2 clk = ~clk;

	src_item_t      pending_items[$];
	ctls_pkg::tok_t expected_tokens[$];
	int          items_queued = 0;
	int          items_accepted = 0;
	int          error_count = 0;
	int          send_idle_pct = 16;
	int          recv_idle_pct = 48;

	scan_state_t scan_state = SCAN_IDLE;
	logic [7:0]  held_chr = 8'h00;
	logic [3:0]  held_kind = 4'h0;
	logic        held_valid = 1'b0;

	function automatic bit is_digit(input logic [7:0] b);
		return b >= ctls_pkg::CH_DIGIT_LO && b <= ctls_pkg::CH_DIGIT_HI;
	endfunction

	function automatic bit is_ident_char(input logic [7:0] b);
		return is_digit(b) || (b >= ctls_pkg::CH_UPPER_LO && b <= ctls_pkg::CH_UPPER_HI) ||
			(b >= ctls_pkg::CH_LOWER_LO && b <= ctls_pkg::CH_LOWER_HI) ||
			b == ctls_pkg::CH_UNDERSCORE || b >= ctls_pkg::CH_HIGH;
	endfunction

	function automatic void emit_token(input logic [3:0] kind, input logic [7:0] chr,
			input logic chr_valid, input logic last);
		ctls_pkg::tok_t t;
		t.kind = kind;
		t.chr = chr;
		t.char_valid = chr_valid;
		t.last = last;
		expected_tokens.push_back(t);
	endfunction

	function automatic void hold_char(input logic [7:0] b, input logic [3:0] kind,
			input scan_state_t next_state);
		held_chr = b;
		held_kind = kind;
		held_valid = 1'b1;
		scan_state = next_state;
	endfunction

	function automatic void begin_token(input logic [7:0] b);
		scan_state = SCAN_IDLE;
		held_valid = 1'b0;
		case (b)
		ctls_pkg::CH_SPACE, ctls_pkg::CH_TAB, ctls_pkg::CH_LF: begin
		end
		ctls_pkg::CH_SLASH: hold_char(b, ctls_pkg::K_OPER, SCAN_SLASH);
		ctls_pkg::CH_GT: hold_char(b, ctls_pkg::K_OPER, SCAN_GT);
		ctls_pkg::CH_LT: hold_char(b, ctls_pkg::K_OPER, SCAN_LT);
		ctls_pkg::CH_EQ: hold_char(b, ctls_pkg::K_OPER, SCAN_EQ);
		ctls_pkg::CH_BANG: hold_char(b, ctls_pkg::K_OPER, SCAN_BANG);
		ctls_pkg::CH_PLUS, ctls_pkg::CH_MINUS, ctls_pkg::CH_STAR, ctls_pkg::CH_PERCENT:
			emit_token(ctls_pkg::K_OPER, b, 1'b1, 1'b1);
		ctls_pkg::CH_COMMA: emit_token(ctls_pkg::K_COMMA, b, 1'b1, 1'b1);
		ctls_pkg::CH_LPAREN: emit_token(ctls_pkg::K_LPAREN, b, 1'b1, 1'b1);
		ctls_pkg::CH_RPAREN: emit_token(ctls_pkg::K_RPAREN, b, 1'b1, 1'b1);
		ctls_pkg::CH_LBRACE: emit_token(ctls_pkg::K_LBRACE, b, 1'b1, 1'b1);
		ctls_pkg::CH_RBRACE: emit_token(ctls_pkg::K_RBRACE, b, 1'b1, 1'b1);
		ctls_pkg::CH_SEMI: emit_token(ctls_pkg::K_SEMI, b, 1'b1, 1'b1);
		default: begin
			if (is_digit(b))
				hold_char(b, ctls_pkg::K_NUM, SCAN_NUM);
			else if (is_ident_char(b))
				hold_char(b, ctls_pkg::K_IDENT, SCAN_IDENT);
			else
				emit_token(ctls_pkg::K_ERR, b, 1'b1, 1'b1);
		end
		endcase
	endfunction

	function automatic void pair_operator(input logic [7:0] b, input logic [7:0] second_a,
			input logic [7:0] second_b);
		if (b == second_a || b == second_b) begin
			emit_token(ctls_pkg::K_OPER, held_chr, 1'b1, 1'b0);
			emit_token(ctls_pkg::K_OPER, b, 1'b1, 1'b1);
			scan_state = SCAN_IDLE;
			held_valid = 1'b0;
		end else begin
			emit_token(ctls_pkg::K_OPER, held_chr, 1'b1, 1'b1);
			begin_token(b);
		end
	endfunction

	function automatic void scan_item(input logic [7:0] b, input logic eoi);
		if (eoi) begin
			if (held_valid)
				emit_token(held_kind, held_chr, 1'b1, 1'b1);
			emit_token(ctls_pkg::K_END, 8'h00, 1'b0, 1'b1);
			scan_state = SCAN_IDLE;
			held_valid = 1'b0;
			return;
		end
		case (scan_state)
		SCAN_NUM, SCAN_IDENT: begin
			if (scan_state == SCAN_NUM ? is_digit(b) : is_ident_char(b)) begin
				emit_token(held_kind, held_chr, 1'b1, 1'b0);
				held_chr = b;
			end else begin
				emit_token(held_kind, held_chr, 1'b1, 1'b1);
				begin_token(b);
			end
		end
		SCAN_SLASH: begin
			if (b == ctls_pkg::CH_SLASH) begin
				held_valid = 1'b0;
				scan_state = SCAN_LINE;
			end else if (b == ctls_pkg::CH_STAR) begin
				held_valid = 1'b0;
				scan_state = SCAN_BLOCK;
			end else begin
				emit_token(ctls_pkg::K_OPER, held_chr, 1'b1, 1'b1);
				begin_token(b);
			end
		end
		SCAN_GT: pair_operator(b, ctls_pkg::CH_GT, ctls_pkg::CH_EQ);
		SCAN_LT: pair_operator(b, ctls_pkg::CH_LT, ctls_pkg::CH_EQ);
		SCAN_EQ, SCAN_BANG: pair_operator(b, ctls_pkg::CH_EQ, ctls_pkg::CH_EQ);
		SCAN_LINE: begin
			if (b == ctls_pkg::CH_LF)
				scan_state = SCAN_IDLE;
		end
		SCAN_BLOCK: begin
			if (b == ctls_pkg::CH_STAR)
				scan_state = SCAN_STAR;
		end
		SCAN_STAR: begin
			if (b == ctls_pkg::CH_SLASH)
				scan_state = SCAN_IDLE;
			else if (b != ctls_pkg::CH_STAR)
				scan_state = SCAN_BLOCK;
		end
		default: begin_token(b);
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic push_char(input logic [7:0] c);
		src_item_t it;
		it.data = c;
		it.eoi = 1'b0;
		pending_items.push_back(it);
		items_queued++;
	endtask

	task automatic push_eoi();
		src_item_t it;
		it.data = 8'($urandom_range(0, 255));
		it.eoi = 1'b1;
		pending_items.push_back(it);
		items_queued++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i]);
	endtask

	function automatic logic [7:0] rand_ident_char(input bit allow_digit);
		case ($urandom_range(0, allow_digit ? 4 : 3))
		0: return 8'($urandom_range(ctls_pkg::CH_LOWER_LO, ctls_pkg::CH_LOWER_HI));
		1: return 8'($urandom_range(ctls_pkg::CH_UPPER_LO, ctls_pkg::CH_UPPER_HI));
		2: return ctls_pkg::CH_UNDERSCORE;
		3: return 8'($urandom_range(ctls_pkg::CH_HIGH, 8'hFF));
		default: return 8'($urandom_range(ctls_pkg::CH_DIGIT_LO, ctls_pkg::CH_DIGIT_HI));
		endcase
	endfunction

	task automatic push_random_token();
		string pair_ops[6] = '{">>", ">=", "<<", "<=", "==", "!="};
		string singles = "+-*%,(){};/<>=!";
		logic [7:0] spaces[3] = '{ctls_pkg::CH_SPACE, ctls_pkg::CH_TAB, ctls_pkg::CH_LF};
		int pick;
		logic [7:0] c;
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			push_char(rand_ident_char(1'b0));
			repeat ($urandom_range(0, 5))
				push_char(rand_ident_char(1'b1));
		end else if (pick < 32) begin
			repeat ($urandom_range(1, 5))
				push_char(8'($urandom_range(ctls_pkg::CH_DIGIT_LO, ctls_pkg::CH_DIGIT_HI)));
		end else if (pick < 44) begin
			push_text(pair_ops[$urandom_range(0, 5)]);
		end else if (pick < 60) begin
			push_char(singles[$urandom_range(0, singles.len() - 1)]);
		end else if (pick < 72) begin
			repeat ($urandom_range(1, 3))
				push_char(spaces[$urandom_range(0, 2)]);
		end else if (pick < 78) begin
			push_text("//");
			repeat ($urandom_range(0, 8)) begin
				c = 8'($urandom_range(0, 255));
				push_char(c == ctls_pkg::CH_LF ? ctls_pkg::CH_SPACE : c);
			end
			if ($urandom_range(0, 7) != 0)
				push_char(ctls_pkg::CH_LF);
		end else if (pick < 86) begin
			push_text("/*");
			repeat ($urandom_range(0, 8)) begin
				c = 8'($urandom_range(0, 255));
				push_char(c == ctls_pkg::CH_STAR ? ctls_pkg::CH_PLUS : c);
			end
			if ($urandom_range(0, 9) != 0) begin
				repeat ($urandom_range(1, 3))
					push_char(ctls_pkg::CH_STAR);
				push_char(ctls_pkg::CH_SLASH);
			end
		end else if (pick < 94) begin
			push_char($urandom_range(0, 3) == 0 ? 8'h0D : 8'($urandom_range(0, 255)));
		end else begin
			push_eoi();
		end
	endtask

	task automatic push_random_source(input int n_items);
		int target;
		target = items_queued + n_items;
		while (items_queued < target)
			push_random_token();
	endtask

	task automatic drain_source();
		while (items_accepted != items_queued)
			@(posedge clk);
	endtask

	always @(posedge clk) begin : drive_bytes
		src_item_t it;
		if (arst_n) begin
			if (byte_if.valid && byte_if.ready) begin
				scan_item(byte_if.source_byte, byte_if.end_of_input);
				items_accepted++;
			end
			if (!byte_if.valid || byte_if.ready) begin
				if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					it = pending_items.pop_front();
					byte_if.valid <= 1'b1;
					byte_if.source_byte <= it.data;
					byte_if.end_of_input <= it.eoi;
				end else begin
					byte_if.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : check_tokens
		ctls_pkg::tok_t want;
		if (arst_n) begin
			if (token_if.valid && token_if.ready) begin
				if (expected_tokens.size() == 0) begin
					report_mismatch($sformatf("unexpected token kind=%0d char=%02h valid=%0b last=%0b",
						token_if.token_kind, token_if.token_char, token_if.char_valid,
						token_if.token_last));
				end else begin
					want = expected_tokens.pop_front();
					if (token_if.token_kind !== want.kind)
						report_mismatch($sformatf("token_kind %0d, want %0d",
							token_if.token_kind, want.kind));
					if (token_if.token_char !== want.chr)
						report_mismatch($sformatf("token_char %02h, want %02h",
							token_if.token_char, want.chr));
					if (token_if.char_valid !== want.char_valid)
						report_mismatch($sformatf("char_valid %0b, want %0b",
							token_if.char_valid, want.char_valid));
					if (token_if.token_last !== want.last)
						report_mismatch($sformatf("token_last %0b, want %0b",
							token_if.token_last, want.last));
				end
			end
			token_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		#(2_000_000);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		byte_if.valid = 1'b0;
		byte_if.source_byte = 8'h00;
		byte_if.end_of_input = 1'b0;
		token_if.ready = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		push_char(8'h00);
		push_char(8'hFF);
		push_text("9>>a<=!=/***/");
		push_char(8'h0D);
		push_text("1//x\n/");
		push_eoi();
		push_text("/*");
		push_eoi();
		push_random_source(450);
		drain_source();

		send_idle_pct = 48;
		recv_idle_pct = 16;
		push_random_source(475);
		drain_source();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		push_random_source(475);
		push_eoi();
		drain_source();

		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (4 * ctls_pkg::QDEPTH) @(posedge clk);

		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/ctls_pkg.sv
rtl/core/ctls_if.sv
rtl/core/ctls_front.sv
rtl/core/ctls_queue.sv
rtl/core/ctls_back.sv
rtl/core/c_like_token_scanner_core.sv
tb/sv/c_like_token_scanner_core_tb.sv
